/* rtl/lkv_pkg.sv */
package lkv_pkg;

  localparam int unsigned LKV_ENTRIES = 16;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // register byte address of capacity
  localparam logic [2:0] CAP_ADDR = 3'd0;

  localparam logic [VAL_W-1:0] MISS_VALUE  = '1;
  localparam logic [VAL_W-1:0] STORE_VALUE = '0;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_STORE  = 1'b1
  } action_e;

  // how the row moves on an update
  typedef enum logic [1:0] {
    MODE_HIT    = 2'd0,
    MODE_EVICT  = 2'd1,
    MODE_INSERT = 2'd2
  } upd_mode_e;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             update;
    upd_mode_e        mode;
    logic [KEY_W-1:0] key;
  } ctl_t;

endpackage

/* rtl/lkv_cell.sv */
module lkv_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lkv_pkg::ctl_t  ctl_i,
  input  lkv_pkg::entry_t prev_i,
  input  logic           found_i,
  output logic           found_o,
  output logic           hit_o,
  output lkv_pkg::entry_t entry_o
);
  import lkv_pkg::*;

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic             shift;

  assign hit_o   = valid_q && (key_q == ctl_i.key);
  assign found_o = found_i | hit_o;
  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

  // cells up to the chosen slot take their neighbor's entry
  always_comb begin
    unique case (ctl_i.mode)
      MODE_HIT:    shift = !found_i;
      MODE_EVICT:  shift = valid_q;
      MODE_INSERT: shift = 1'b1;
      default:     shift = 1'b0;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.update && shift) begin
      valid_d = prev_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.update && shift) begin
      key_q   <= prev_i.key;
      value_q <= prev_i.value;
    end
  end

endmodule

/* rtl/lru_key_value_cache.sv */
// key/value store with least-recently-used replacement, built as a row of
// cells ordered by recency: the head cell holds the most recent entry.
// input beats arrive on s_axis: tuser is the action (0 lookup, 1 store),
// tdata carries key and value. each beat gives one result beat on m_axis:
// tuser is hit, tdata is the value read (-1 on a lookup miss, 0 on store).
// every beat is handled in the cycle it is accepted: all cells compare the
// key at once and, except on a lookup miss, the row shifts toward the tail up to
// the hit, evicted or free slot, so one beat per cycle is sustained unless the
// receiver stalls; the registered result appears in the cycle after acceptance.
// the broadcast compare across the cell row sets the length of that step.
// the result sits in an output register; a new beat is taken whenever that
// register is empty or being drained, so a stalled receiver holds s_axis off
// only while a result is waiting.
// capacity is written over apb at byte address 0, by the user only while the block is idle;
// the block does not enforce this. reset empties the store and sets capacity to 16.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = lkv_pkg::LKV_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // read_value [31:0]
  output logic        m_axis_tuser,   // hit
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lkv_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic             out_hit_q, out_hit_d;
  logic [VAL_W-1:0] out_value_q, out_value_d;

  logic             accept;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_value;
  action_e          in_action;

  ctl_t             ctl;
  entry_t           new_entry;
  entry_t           ent   [ENTRIES];
  logic             fnd   [ENTRIES+1];
  logic [ENTRIES-1:0] hit_vec;
  logic             hit_any;
  logic [VAL_W-1:0] hit_value;
  logic [CMP_W-1:0] cap_ext, eff_cap;
  logic             full;

  assign in_key    = s_axis_tdata[31:0];
  assign in_value  = s_axis_tdata[63:32];
  assign in_action = action_e'(s_axis_tuser);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr == CAP_ADDR) ? 32'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == CAP_ADDR)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full = CMP_W'(count_q) >= eff_cap;

  // cell row
  assign fnd[0]  = 1'b0;
  assign hit_any = fnd[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t prev;
    if (i == 0) begin : g_head
      assign prev = new_entry;
    end else begin : g_body
      assign prev = ent[i-1];
    end
    lkv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .prev_i  (prev),
      .found_i (fnd[i]),
      .found_o (fnd[i+1]),
      .hit_o   (hit_vec[i]),
      .entry_o (ent[i])
    );
  end

  // keys are unique, so at most one cell hits
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (ent[i].value & {VAL_W{hit_vec[i]}});
    end
  end

  always_comb begin
    ctl.key    = in_key;
    ctl.update = accept && (hit_any || (in_action == ACT_STORE));
    if (hit_any) begin
      ctl.mode = MODE_HIT;
    end else if (full) begin
      ctl.mode = MODE_EVICT;
    end else begin
      ctl.mode = MODE_INSERT;
    end
    new_entry.valid = 1'b1;
    new_entry.key   = in_key;
    new_entry.value = (in_action == ACT_STORE) ? in_value : hit_value;
  end

  always_comb begin
    count_d = count_q;
    if (ctl.update && ctl.mode == MODE_INSERT) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_hit_d = hit_any;
    if (in_action == ACT_STORE) begin
      out_value_d = STORE_VALUE;
    end else if (hit_any) begin
      out_value_d = hit_value;
    end else begin
      out_value_d = MISS_VALUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_hit_q   <= out_hit_d;
      out_value_q <= out_value_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_hit_q;

endmodule

/* verif/lru_cache_checker.sv */
`timescale 1ns / 100ps

// watches both stream channels and the apb port, keeps its own copy of the
// cache contents and recency order, and compares every result beat
module lru_cache_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key [31:0], value [63:32]
  input  logic        s_axis_tuser,   // action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // read_value [31:0]
  input  logic        m_axis_tuser,   // hit
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count
);
  import lkv_pkg::*;

  localparam int unsigned SLOTS     = LKV_ENTRIES;
  localparam int unsigned DUE_DEPTH = 8;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] data;
  } reply_t;

  logic [KEY_W-1:0] slot_key  [SLOTS];
  logic [VAL_W-1:0] slot_val  [SLOTS];
  bit               slot_used [SLOTS];
  int unsigned      slot_rank [SLOTS];
  int unsigned      used_count;
  logic [CAP_W-1:0] capacity;

  // ring of predicted results still owed by the block
  reply_t      replies_due [DUE_DEPTH];
  int unsigned due_head;
  int unsigned due_tail;

  assign pending_count = int'(due_tail - due_head);

  // rank 0 is the most recent; entries younger than the touched one age by one
  function automatic void promote(input int s, input int unsigned old_rank);
    int i;
    for (i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  function automatic void access_cache(input action_e act, input logic [KEY_W-1:0] key,
                                       input logic [VAL_W-1:0] val, output reply_t reply);
    int          i;
    int          found;
    int          victim;
    int unsigned oldest;
    int unsigned limit;
    found = -1;
    for (i = 0; i < SLOTS; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == key) found = i;
    end
    if (found >= 0) begin
      reply.hit = 1'b1;
      if (act == ACT_LOOKUP) begin
        reply.data = slot_val[found];
      end else begin
        slot_val[found] = val;
        reply.data = STORE_VALUE;
      end
      promote(found, slot_rank[found]);
      return;
    end
    reply.hit = 1'b0;
    if (act == ACT_LOOKUP) begin
      reply.data = MISS_VALUE;
      return;
    end
    reply.data = STORE_VALUE;
    // zero behaves as one, anything above the slot count saturates
    limit = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : capacity);
    if (used_count >= limit) begin
      victim = -1;
      oldest = 0;
      for (i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && (victim < 0 || slot_rank[i] > oldest)) begin
          victim = i;
          oldest = slot_rank[i];
        end
      end
      if (victim >= 0) begin
        slot_key[victim] = key;
        slot_val[victim] = val;
        promote(victim, oldest);
        return;
      end
    end
    for (i = 0; i < SLOTS; i++) begin
      if (!slot_used[i]) begin
        for (int j = 0; j < SLOTS; j++) begin
          if (slot_used[j]) slot_rank[j]++;
        end
        slot_used[i] = 1'b1;
        slot_key[i]  = key;
        slot_val[i]  = val;
        slot_rank[i] = 0;
        used_count++;
        return;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i]  = '0;
        slot_val[i]  = '0;
        slot_used[i] = 1'b0;
        slot_rank[i] = 0;
      end
      used_count = 0;
      capacity   = CAP_RESET;
      fail_count = 0;
      due_head   = 0;
      due_tail   = 0;
    end else begin
      // result beats belong to earlier input beats, so retire before predicting
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit  = m_axis_tuser;
        got.data = m_axis_tdata;
        if (due_tail == due_head) begin
          $display("%0t: result beat with none expected: hit=%0d value=%h",
                   $time, got.hit, got.data);
          fail_count++;
        end else begin
          want = replies_due[due_head % DUE_DEPTH];
          due_head++;
          if (got.hit !== want.hit) begin
            $display("%0t: hit mismatch: expected %0d, actual %0d",
                     $time, want.hit, got.hit);
            fail_count++;
          end
          if (got.data !== want.data) begin
            $display("%0t: read_value mismatch: expected %h, actual %h",
                     $time, want.data, got.data);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        access_cache(action_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32], want);
        if (due_tail - due_head >= DUE_DEPTH) begin
          $display("%0t: too many results outstanding: expected at most %0d, actual %0d",
                   $time, DUE_DEPTH, due_tail - due_head + 1);
          fail_count++;
        end else begin
          replies_due[due_tail % DUE_DEPTH] = want;
          due_tail++;
        end
      end
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
        capacity = pwdata[CAP_W-1:0];
      end
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import lkv_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // key [31:0], value [63:32]
  logic        s_axis_tuser;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // read_value [31:0]
  logic        m_axis_tuser;   // hit
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  bit steady = 1'b0;

  lru_key_value_cache DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  lru_cache_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver stalls now and then, except during the steady stretch
  always @(negedge clk_i) begin
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 7);
  end

  task automatic send_beat(input action_e act, input logic [31:0] key,
                           input logic [31:0] val);
    while (!steady && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, key};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // keys mostly come from a small pool around a random base so hits and
  // evictions are frequent; a few are fully random
  function automatic logic [31:0] pick_key(input logic [31:0] base, input int span);
    if ($urandom_range(0, 19) == 0) return $urandom();
    return base ^ 32'($urandom_range(0, span - 1));
  endfunction

  initial begin
    int          caps [8];
    int          eff;
    logic [31:0] base;
    action_e     act;
    caps = '{16, 1, 4, 31, 8, 0, 3, 12};

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_LOOKUP;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty store, extreme keys and values, overwrite on hit
    send_beat(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_beat(ACT_STORE,  32'h8000_0000, 32'h7fff_ffff);
    send_beat(ACT_STORE,  32'h7fff_ffff, 32'h8000_0000);
    send_beat(ACT_STORE,  32'h0000_0000, 32'h0000_0000);
    send_beat(ACT_STORE,  32'hffff_ffff, 32'hffff_ffff);
    send_beat(ACT_LOOKUP, 32'h8000_0000, 32'hffff_ffff);
    send_beat(ACT_LOOKUP, 32'h7fff_ffff, 32'h0000_0000);
    send_beat(ACT_LOOKUP, 32'h0000_0000, 32'h5555_aaaa);
    send_beat(ACT_LOOKUP, 32'hffff_ffff, 32'haaaa_5555);
    send_beat(ACT_STORE,  32'h0000_0000, 32'h1234_5678);
    send_beat(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_beat(ACT_LOOKUP, 32'h0000_0001, 32'h0000_0000);

    // capacity dropped below occupancy: each store miss replaces one entry
    wait_drained();
    apb_write(CAP_ADDR, 32'd2);
    send_beat(ACT_STORE,  32'h0000_0005, 32'hdead_beef);
    send_beat(ACT_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_beat(ACT_LOOKUP, 32'h0000_0005, 32'h0000_0000);

    // zero capacity acts as one
    wait_drained();
    apb_write(CAP_ADDR, 32'd0);
    send_beat(ACT_STORE,  32'h0000_0006, 32'h0000_0066);
    send_beat(ACT_STORE,  32'h0000_0007, 32'h0000_0077);
    send_beat(ACT_LOOKUP, 32'h0000_0006, 32'h0000_0000);

    // oversize capacity saturates; a write past the register list is dropped
    wait_drained();
    apb_write(CAP_ADDR, 32'd31);
    @(negedge clk_i);
    apb_write(3'd4, 32'd1);
    send_beat(ACT_STORE,  32'h0000_0008, 32'h0000_0088);
    send_beat(ACT_STORE,  32'h0000_0009, 32'h0000_0099);
    send_beat(ACT_LOOKUP, 32'h0000_0007, 32'h0000_0000);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      apb_write(CAP_ADDR, 32'(caps[ph]));
      eff    = (caps[ph] == 0) ? 1 : ((caps[ph] > 16) ? 16 : caps[ph]);
      base   = $urandom();
      steady = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        if (ph == 4 && n == 50) wait_drained();
        act = ($urandom_range(0, 1) == 1) ? ACT_STORE : ACT_LOOKUP;
        send_beat(act, pick_key(base, eff + 3), $urandom());
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
